// ===== sv/ptca_pkg.sv =====
// Shared constants and codes for the partitioned task core allocator.
package ptca_pkg;

    // Field widths
    localparam int LOAD_W     = 16;
    localparam int UTIL_W     = 17;
    localparam int CAP_W      = 17;
    localparam int MODE_W     = 2;
    localparam int IDX_OUT_W  = 2;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 17;

    // Saturated capacity, 1.0 in fixed point
    localparam logic [CAP_W-1:0] CAP_MAX = 17'h10000;

    // Fit policies
    localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

    // Item functions
    localparam logic FUNC_ASSIGN = 1'b0;
    localparam logic FUNC_CLEAR  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_FIT_MODE      = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CORE_CAPACITY = 1'd1;

endpackage

// ===== sv/ptca_pick.sv =====
// Fit test and policy pick across all cores, one-hot winner out (all zero if no core fits).
module ptca_pick #(
    parameter int NUM_CORES = 4
) (
    input  logic [NUM_CORES-1:0][ptca_pkg::LOAD_W-1:0] i_load,
    input  logic [ptca_pkg::UTIL_W-1:0]                 i_util,
    input  logic [ptca_pkg::CAP_W-1:0]                  i_cap,
    input  logic [ptca_pkg::MODE_W-1:0]                 i_mode,
    output logic [NUM_CORES-1:0]                        o_win
);

    logic [NUM_CORES-1:0] w_fits;
    logic                 w_best;
    logic                 w_worst;

    assign w_best  = (i_mode == ptca_pkg::FIT_BEST);
    assign w_worst = (i_mode == ptca_pkg::FIT_WORST);

    // Per-core fit: load + util strictly below capacity
    always_comb begin
        for (int c = 0; c < NUM_CORES; c++) begin
            w_fits[c] = ({2'b00, i_load[c]} + {1'b0, i_util}) < {1'b0, i_cap};
        end
    end

    // Pairwise contest: a fitting core wins if it beats every other fitting core;
    // lower index takes ties. Unused mode falls back to first fit.
    always_comb begin
        for (int c = 0; c < NUM_CORES; c++) begin
            o_win[c] = w_fits[c];
            for (int j = 0; j < NUM_CORES; j++) begin
                if (j < c) begin
                    if (w_best) begin
                        o_win[c] = o_win[c] & (!w_fits[j] || (i_load[c] > i_load[j]));
                    end else if (w_worst) begin
                        o_win[c] = o_win[c] & (!w_fits[j] || (i_load[c] < i_load[j]));
                    end else begin
                        o_win[c] = o_win[c] & !w_fits[j];
                    end
                end else if (j > c) begin
                    if (w_best) begin
                        o_win[c] = o_win[c] & (!w_fits[j] || (i_load[c] >= i_load[j]));
                    end else if (w_worst) begin
                        o_win[c] = o_win[c] & (!w_fits[j] || (i_load[c] <= i_load[j]));
                    end
                end
            end
        end
    end

endmodule

// ===== sv/partitioned_task_core_allocator_unit.sv =====
// Top level of the partitioned task core allocator: item pipeline and core loads.
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+------------------------------------------
//  input    | in        | i_valid / o_stall | i_func, i_task_util
//  result   | out       | o_valid / i_stall | o_placed, o_core_index, o_core_load_after
//  config   | in        | i_cfg_we          | i_cfg_addr, i_cfg_wdata
//
// One item per cycle sustained while the result is not stalled; each item passes through
// the input register and then the result register. The fit test and pick run in
// one pass, and the core loads update in the same cycle, ready for the next item.
// Synchronous active-low reset zeroes all core loads and sets first fit, capacity 1.0.
// A stalled result holds the pipeline; the input stalls only while both stages are full
// and the result is stalled.
module partitioned_task_core_allocator_unit #(
    parameter int NUM_CORES = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration
    input  logic                            i_cfg_we,
    input  logic [ptca_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [ptca_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    // Input items
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_func,
    input  logic [ptca_pkg::UTIL_W-1:0]     i_task_util,
    // Result items
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_placed,
    output logic [ptca_pkg::IDX_OUT_W-1:0]  o_core_index,
    output logic [ptca_pkg::LOAD_W-1:0]     o_core_load_after
);

    localparam int IDX_W = $clog2(NUM_CORES);
    localparam int ENC_W = (IDX_W < ptca_pkg::IDX_OUT_W) ? ptca_pkg::IDX_OUT_W : IDX_W;

    // Configuration registers
    logic [ptca_pkg::MODE_W-1:0] r_fit_mode;
    logic [ptca_pkg::CAP_W-1:0]  r_capacity;
    logic [ptca_pkg::CAP_W-1:0]  w_cap_sat;

    // Input stage
    logic                        r_in_valid;
    logic                        r_func;
    logic [ptca_pkg::UTIL_W-1:0] r_util;

    // Core loads
    logic [NUM_CORES-1:0][ptca_pkg::LOAD_W-1:0] r_core_load;

    // Result stage
    logic                           r_out_valid;
    logic                           r_placed;
    logic [ptca_pkg::IDX_OUT_W-1:0] r_core_index;
    logic [ptca_pkg::LOAD_W-1:0]    r_load_after;

    // Pick results
    logic [NUM_CORES-1:0]        w_win;
    logic                        w_placed;
    logic [ENC_W-1:0]            w_idx;
    logic [ptca_pkg::LOAD_W-1:0] w_sel_load;
    logic [ptca_pkg::LOAD_W-1:0] w_new_load;
    logic                        w_adv;
    logic                        w_assign;

    // Capacity above 1.0 saturates
    assign w_cap_sat = r_capacity[ptca_pkg::CAP_W-1] ? ptca_pkg::CAP_MAX : r_capacity;

    ptca_pick #(
        .NUM_CORES (NUM_CORES)
    ) u_pick (
        .i_load (r_core_load),
        .i_util (r_util),
        .i_cap  (w_cap_sat),
        .i_mode (r_fit_mode),
        .o_win  (w_win)
    );

    // One-hot winner to index and selected load
    always_comb begin
        w_idx      = '0;
        w_sel_load = '0;
        for (int c = 0; c < NUM_CORES; c++) begin
            if (w_win[c]) begin
                w_idx      = w_idx | ENC_W'(c);
                w_sel_load = w_sel_load | r_core_load[c];
            end
        end
    end

    assign w_assign   = (r_func == ptca_pkg::FUNC_ASSIGN);
    assign w_placed   = w_assign && (|w_win);
    assign w_new_load = w_sel_load + r_util[ptca_pkg::LOAD_W-1:0];

    // Pipeline control
    assign w_adv   = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !w_adv;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fit_mode <= ptca_pkg::FIT_FIRST;
            r_capacity <= ptca_pkg::CAP_MAX;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                ptca_pkg::REG_FIT_MODE:      r_fit_mode <= i_cfg_wdata[ptca_pkg::MODE_W-1:0];
                ptca_pkg::REG_CORE_CAPACITY: r_capacity <= i_cfg_wdata[ptca_pkg::CAP_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_func <= i_func;
            r_util <= i_task_util;
        end
    end

    // Core load update: clear zeroes all, a placement grows the winner
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_core_load <= '0;
        end else if (w_adv) begin
            if (!w_assign) begin
                r_core_load <= '0;
            end else begin
                for (int c = 0; c < NUM_CORES; c++) begin
                    if (w_win[c]) begin
                        r_core_load[c] <= w_new_load;
                    end
                end
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_placed     <= w_placed;
            r_core_index <= w_placed ? w_idx[ptca_pkg::IDX_OUT_W-1:0] : '0;
            r_load_after <= w_placed ? w_new_load : '0;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_placed          = r_placed;
    assign o_core_index      = r_core_index;
    assign o_core_load_after = r_load_after;

    // At most one core wins a contest for a held item
    a_win_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |-> $onehot0(w_win))
        else $error("more than one core picked");

    // An unplaced result carries zero index and load
    a_unplaced_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_placed) |-> (o_core_index == '0 && o_core_load_after == '0))
        else $error("unplaced result with nonzero fields");

    // A clear item leaves every load at zero
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_func == ptca_pkg::FUNC_CLEAR) |=> (r_core_load == '0))
        else $error("core loads not cleared");

    // An advancing item always shows up as a result next cycle
    a_adv_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_adv |=> o_valid)
        else $error("advanced item lost");

endmodule
